// ===== rtl/rrds_pkg.sv =====
// ----------------------------------------------------------------------------
// rrds_pkg
// Shared types and constants for the round-robin DMA scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrds_pkg;

    localparam int WORKERS_DEF  = 8;
    localparam int TPT_DEF      = 4;

    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_LSB  = 3;
    localparam int DEV_REG_NUM  = 4;
    localparam int DEV_NUM      = DEV_REG_NUM * CFG_DATA_W;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic RK_REPLY = 1'b0;
    localparam logic RK_XFER  = 1'b1;

    localparam logic [2:0] CHUNK_MAX    = 3'd4;
    localparam logic [2:0] RESULT_LIMIT = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  device_id;
        logic [15:0] mem_address;
        logic [15:0] byte_length;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic        accepted;
        logic [2:0]  worker_slot;
        logic [7:0]  xfer_device;
        logic [15:0] xfer_address;
        logic [2:0]  xfer_bytes;
        logic        xfer_direction;
        logic        last;
    } out_item_t;

    // classified command handed from the front end to the engine
    typedef struct packed {
        logic        is_tick;
        logic        dir;
        logic [7:0]  device;
        logic [15:0] base;
        logic [15:0] length;
    } cmd_t;

    typedef struct packed {
        logic        dir;
        logic [7:0]  device;
        logic [15:0] base;
        logic [15:0] length;
        logic [15:0] pos;
    } slot_t;

endpackage

`default_nettype wire

// ===== rtl/rrds_cfg.sv =====
// ----------------------------------------------------------------------------
// rrds_cfg
// APB register file holding the device presence bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rrds_cfg
    import rrds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [DEV_NUM-1:0]    present
);

    logic [CFG_DATA_W-1:0] dev_reg [DEV_REG_NUM];
    logic [1:0]            idx;
    logic                  wr_en;

    assign idx    = paddr[CFG_IDX_LSB +: 2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = dev_reg[idx];

    always_comb
    begin
        for (int i = 0; i < DEV_REG_NUM; i++)
        begin
            present[i*CFG_DATA_W +: CFG_DATA_W] = dev_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEV_REG_NUM; i++)
            begin
                dev_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            dev_reg[idx] <= pwdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rrds_front.sv =====
// ----------------------------------------------------------------------------
// rrds_front
// Input side: classifies beats into commands and queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rrds_front
    import rrds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  wire logic     cmd_pop
);

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       q_mem [2];
    cmd_t       new_cmd;
    logic       push;
    logic       pop;

    // unused kind code is taken and dropped
    always_comb
    begin
        new_cmd.is_tick = (in_data.kind == KIND_TICK);
        new_cmd.dir     = (in_data.kind == KIND_WRITE);
        new_cmd.device  = in_data.device_id;
        new_cmd.base    = in_data.mem_address;
        new_cmd.length  = in_data.byte_length;
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall && (in_data.kind inside {KIND_READ, KIND_WRITE,
                                                                    KIND_TICK});
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rrds_engine.sv =====
// ----------------------------------------------------------------------------
// rrds_engine
// Back end: slot table, start allocation, round-robin service passes and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrds_engine
    import rrds_pkg::*;
#(
    parameter int WORKERS            = WORKERS_DEF,
    parameter int TRANSFERS_PER_TICK = TPT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire cmd_t               cmd,
    output logic                    cmd_pop,
    input  wire logic [DEV_NUM-1:0] present,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_item_t               out_data
);

    localparam int SLOT_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int CNT_W  = $clog2(WORKERS + 1);
    localparam int PASS_W = $clog2(TRANSFERS_PER_TICK + 1);
    localparam int CMP_W  = (CNT_W > PASS_W) ? CNT_W : PASS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_SERVE,
        ST_FLUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [WORKERS-1:0]  slot_active_reg, slot_active_next;
    logic [CNT_W-1:0]    active_count_reg, active_count_next;
    logic [SLOT_W-1:0]   next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic [SLOT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic [2:0]          n_reg, n_next;
    out_item_t           hold_reg, hold_next;
    logic                hold_valid_reg, hold_valid_next;
    out_item_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    slot_t               slot_mem [WORKERS];
    slot_t               rd_reg;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    slot_t               mem_wdata;
    logic                mem_re;

    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
    logic                out_free;
    logic [SLOT_W-1:0]   cur_inc;
    logic                pass_ok;
    logic [15:0]         diff;
    logic [2:0]          amount;
    logic [16:0]         sum_pos;
    logic                done;
    logic                dev_ok;
    out_item_t           xfer;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = WORKERS - 1; i >= 0; i--)
        begin
            if (!slot_active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign cur_inc  = (cur_reg == SLOT_W'(WORKERS - 1)) ? '0 : cur_reg + SLOT_W'(1);
    assign pass_ok  = (CMP_W'(pass_reg) < CMP_W'(active_count_reg))
                   && (CMP_W'(pass_reg) < CMP_W'(TRANSFERS_PER_TICK));

    always_comb
    begin
        diff    = rd_reg.length - rd_reg.pos;
        if (rd_reg.length <= rd_reg.pos)
        begin
            amount = 3'd0;
        end
        else if (diff > 16'(CHUNK_MAX))
        begin
            amount = CHUNK_MAX;
        end
        else
        begin
            amount = diff[2:0];
        end
        sum_pos = {1'b0, rd_reg.pos} + {14'd0, amount};
        done    = (sum_pos >= {1'b0, rd_reg.length});
        dev_ok  = present[rd_reg.device];

        xfer.result_kind    = RK_XFER;
        xfer.accepted       = 1'b0;
        xfer.worker_slot    = 3'(cur_reg);
        xfer.xfer_device    = rd_reg.device;
        xfer.xfer_address   = rd_reg.base + rd_reg.pos;
        xfer.xfer_bytes     = amount;
        xfer.xfer_direction = rd_reg.dir;
        xfer.last           = 1'b0;
    end

    always_comb
    begin
        state_next        = state_reg;
        slot_active_next  = slot_active_reg;
        active_count_next = active_count_reg;
        next_slot_next    = next_slot_reg;
        cur_next          = cur_reg;
        scan_cnt_next     = scan_cnt_reg;
        pass_next         = pass_reg;
        n_next            = n_reg;
        hold_next         = hold_reg;
        hold_valid_next   = hold_valid_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && out_stall;
        cmd_pop           = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = cur_reg;
        mem_wdata         = rd_reg;
        mem_re            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.is_tick)
                begin
                    cmd_pop       = 1'b1;
                    cur_next      = next_slot_reg;
                    scan_cnt_next = '0;
                    pass_next     = '0;
                    n_next        = 3'd0;
                    state_next    = ST_SCAN;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.result_kind = RK_REPLY;
                    out_next.last  = 1'b1;
                    if (free_found)
                    begin
                        out_next.accepted    = 1'b1;
                        out_next.worker_slot = 3'(free_idx);
                        slot_active_next[free_idx] = 1'b1;
                        active_count_next = active_count_reg + CNT_W'(1);
                        mem_we           = 1'b1;
                        mem_waddr        = free_idx;
                        mem_wdata.dir    = cmd.dir;
                        mem_wdata.device = cmd.device;
                        mem_wdata.base   = cmd.base;
                        mem_wdata.length = cmd.length;
                        mem_wdata.pos    = 16'd0;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!pass_ok)
                begin
                    state_next = ST_FLUSH;
                end
                else if (slot_active_reg[cur_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = ST_READ;
                end
                else if (scan_cnt_reg == SLOT_W'(WORKERS - 1))
                begin
                    next_slot_next = '0;
                    state_next     = ST_FLUSH;
                end
                else
                begin
                    cur_next      = cur_inc;
                    scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
                end
            end

            ST_READ:
            begin
                state_next = ST_SERVE;
            end

            ST_SERVE:
            begin
                if (amount == 3'd0 || !dev_ok)
                begin
                    slot_active_next[cur_reg] = 1'b0;
                    active_count_next = active_count_reg - CNT_W'(1);
                    next_slot_next    = cur_inc;
                    pass_next         = pass_reg + PASS_W'(1);
                    cur_next          = cur_inc;
                    scan_cnt_next     = '0;
                    state_next        = ST_SCAN;
                end
                else if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next       = hold_reg;
                        out_valid_next = 1'b1;
                    end
                    hold_next       = xfer;
                    hold_valid_next = 1'b1;
                    n_next          = n_reg + 3'd1;
                    if (done)
                    begin
                        slot_active_next[cur_reg] = 1'b0;
                        active_count_next = active_count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        mem_we        = 1'b1;
                        mem_wdata.pos = sum_pos[15:0];
                    end
                    next_slot_next = cur_inc;
                    pass_next      = pass_reg + PASS_W'(1);
                    cur_next       = cur_inc;
                    scan_cnt_next  = '0;
                    state_next     = (n_reg + 3'd1 == RESULT_LIMIT) ? ST_FLUSH : ST_SCAN;
                end
            end

            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = hold_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= slot_mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_active_reg  <= '0;
            active_count_reg <= '0;
            next_slot_reg    <= '0;
            cur_reg          <= '0;
            scan_cnt_reg     <= '0;
            pass_reg         <= '0;
            n_reg            <= 3'd0;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_active_reg  <= slot_active_next;
            active_count_reg <= active_count_next;
            next_slot_reg    <= next_slot_next;
            cur_reg          <= cur_next;
            scan_cnt_reg     <= scan_cnt_next;
            pass_reg         <= pass_next;
            n_reg            <= n_next;
            hold_valid_reg   <= hold_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        active_count_reg == CNT_W'($countones(slot_active_reg)))
        else $error("active count out of step with slot table");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !hold_valid_reg)
        else $error("held transfer beat left behind at end of tick");

    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RESULT_LIMIT)
        else $error("too many transfer beats in one tick");

    a_next_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(next_slot_reg) < WORKERS)
        else $error("next slot pointer out of range");

endmodule

`default_nettype wire

// ===== rtl/round_robin_dma_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_dma_scheduler_unit
// DMA channel table with round-robin service ticks.
// ----------------------------------------------------------------------------
// A start beat (read or write) claims the lowest free slot, if there is
// one, and returns one registered reply beat. A tick beat serves up to
// TRANSFERS_PER_TICK active slots, issuing at most four transfer beats; the
// engine checks one slot per cycle while looking for the next active slot,
// and each served slot then passes through a table read state and a serve
// state, which can wait while the output is stalled. A two-entry command
// queue keeps the input open while the engine works. Slot fields live in a
// one-port table inside the engine; only the active bits are reset.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_dma_scheduler_unit
    import rrds_pkg::*;
#(
    parameter int WORKERS            = WORKERS_DEF,
    parameter int TRANSFERS_PER_TICK = TPT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data
);

    logic [DEV_NUM-1:0] present;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;

    rrds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .present (present)
    );

    rrds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    rrds_engine #(
        .WORKERS            (WORKERS),
        .TRANSFERS_PER_TICK (TRANSFERS_PER_TICK)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .present   (present),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
